@@ design/qrr_pkg.sv @@
package qrr_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 40;

    // coefficient magnitude, one bit wider so that the most negative value fits
    localparam int MAG_W  = COEF_WIDTH + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DISC_W = PROD_W + 2;
    // square root of disc * 2^(2*FRAC_BITS), one root bit per cell
    localparam int SQ_W   = (DISC_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int SQR_W  = SQ_W + 3;
    // numerator magnitude and signed numerator
    localparam int NUM_W  = ((MAG_W + FRAC_BITS) > SQ_W ? (MAG_W + FRAC_BITS) : SQ_W) + 1;
    localparam int NV_W   = NUM_W + 1;
    // denominator (2a or b) and rounded quotient, one quotient bit per cell
    localparam int DEN_W  = MAG_W + 1;
    localparam int QW     = NUM_W + 2;
    localparam int QX_W   = QW + OUT_W;
    // index of the valid-beat tap that lines up with the loaded result
    localparam int LAT    = SQ_W + QW + 4;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_ONE  = 2'd1,
        ST_TWO  = 2'd2,
        ST_ALL  = 2'd3
    } t_status;

endpackage

@@ design/quadratic_real_root_solver_unit.sv @@
// real roots of a*x^2 + b*x + c = 0, one equation per cycle, fully pipelined.
// an equation is taken whenever i_start is high (o_busy is always low); its
// result appears on o_root_status / o_root_plus / o_root_minus for one cycle
// with o_valid, loaded into the output register. the equation is registered in
// stages a, p and d, the chain of square-root cells (one root bit each),
// stage n and two chains of divider cells (one quotient bit each). the receiver
// cannot stall: a result is shown once and is gone in the next cycle. roots
// are signed q24.16, rounded to nearest with ties away from zero, saturated to
// 40 bits; absent roots read as zero.
// status: 0 no real root, 1 one root, 2 two roots, 3 every x solves.
module quadratic_real_root_solver_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [qrr_pkg::COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [qrr_pkg::COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [qrr_pkg::COEF_WIDTH-1:0] i_coef_c,
    output logic                                 o_valid,
    output logic [1:0]                           o_root_status,
    output logic signed [qrr_pkg::OUT_W-1:0]     o_root_plus,
    output logic signed [qrr_pkg::OUT_W-1:0]     o_root_minus
);

    // per-equation sideband while disc and sqrt are in flight
    typedef struct packed {
        logic                        fixed;
        qrr_pkg::t_status            fix_st;
        logic                        lin;
        logic                        an;
        logic                        bn;
        logic                        cn;
        logic [qrr_pkg::MAG_W-1:0]   am;
        logic [qrr_pkg::MAG_W-1:0]   bm;
        logic [qrr_pkg::MAG_W-1:0]   cm;
    } t_sq_side;

    // sideband while the dividers run
    typedef struct packed {
        qrr_pkg::t_status st;
        logic             neg_p;
        logic             neg_m;
    } t_dv_side;

    localparam logic [qrr_pkg::QX_W-1:0] MAXP =
        {{(qrr_pkg::QX_W-qrr_pkg::OUT_W+1){1'b0}}, {(qrr_pkg::OUT_W-1){1'b1}}};

    logic w_accept;
    logic [qrr_pkg::LAT:0] r_vld;

    t_sq_side r_a_side, n_a_side;
    t_sq_side r_p_side;
    t_sq_side r_d_side, n_d_side;
    t_sq_side r_sq_side [qrr_pkg::SQ_W];
    t_dv_side r_dv_side [qrr_pkg::QW];
    t_dv_side n_n_side;

    logic [qrr_pkg::PROD_W-1:0] r_bsq, r_ac;
    logic [qrr_pkg::DISC_W-1:0] r_disc, n_disc;
    logic [qrr_pkg::DISC_W-1:0] w_bsq_x, w_fac;

    // magnitude of a coefficient in two's complement
    function automatic logic [qrr_pkg::MAG_W-1:0] mag_of(
        input logic [qrr_pkg::COEF_WIDTH-1:0] x
    );
        logic [qrr_pkg::MAG_W-1:0] ext;
        ext = {x[qrr_pkg::COEF_WIDTH-1], x};
        return x[qrr_pkg::COEF_WIDTH-1] ? (~ext + 1'b1) : ext;
    endfunction

    // saturate a rounded magnitude and apply its sign
    function automatic logic [qrr_pkg::OUT_W-1:0] sat_sign(
        input logic [qrr_pkg::QW-1:0] q,
        input logic                   neg
    );
        logic [qrr_pkg::QX_W-1:0] qx;
        logic [qrr_pkg::QX_W-1:0] qn;
        logic [qrr_pkg::OUT_W-1:0] res;
        qx = qrr_pkg::QX_W'(q);
        qn = ~qx + 1'b1;
        if (!neg) begin
            res = (qx > MAXP) ? MAXP[qrr_pkg::OUT_W-1:0] : qx[qrr_pkg::OUT_W-1:0];
        end else begin
            res = (qx > MAXP + 1'b1) ? {1'b1, {(qrr_pkg::OUT_W-1){1'b0}}}
                                      : qn[qrr_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    // valid beat travels alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[qrr_pkg::LAT-1:0], w_accept};
        end
    end

    // stage a: decode signs and magnitudes
    always_comb begin
        n_a_side        = '0;
        n_a_side.an     = i_coef_a[qrr_pkg::COEF_WIDTH-1];
        n_a_side.bn     = i_coef_b[qrr_pkg::COEF_WIDTH-1];
        n_a_side.cn     = i_coef_c[qrr_pkg::COEF_WIDTH-1];
        n_a_side.am     = mag_of(i_coef_a);
        n_a_side.bm     = mag_of(i_coef_b);
        n_a_side.cm     = mag_of(i_coef_c);
        n_a_side.lin    = (n_a_side.am == '0);
        n_a_side.fix_st = qrr_pkg::ST_NONE;
    end

    // stage p: the two products
    always_ff @(posedge i_clk) begin
        r_a_side <= n_a_side;
        r_p_side <= r_a_side;
        r_bsq    <= r_a_side.bm * r_a_side.bm;
        r_ac     <= r_a_side.am * r_a_side.cm;
    end

    // stage d: discriminant at full width, and the cases with a fixed status
    always_comb begin
        logic dneg;
        w_bsq_x  = qrr_pkg::DISC_W'(r_bsq);
        w_fac    = {r_ac, 2'b00};
        dneg     = 1'b0;
        n_disc   = '0;
        n_d_side = r_p_side;
        if (r_p_side.cm == '0 || r_p_side.an != r_p_side.cn) begin
            n_disc = w_bsq_x + w_fac;
        end else if (w_bsq_x >= w_fac) begin
            n_disc = w_bsq_x - w_fac;
        end else begin
            dneg = 1'b1;
        end
        n_d_side.fixed  = 1'b0;
        n_d_side.fix_st = qrr_pkg::ST_NONE;
        if (r_p_side.lin) begin
            n_d_side.fixed = 1'b1;
            if (r_p_side.bm != '0) begin
                n_d_side.fix_st = qrr_pkg::ST_ONE;
            end else if (r_p_side.cm == '0) begin
                n_d_side.fix_st = qrr_pkg::ST_ALL;
            end else begin
                n_d_side.fix_st = qrr_pkg::ST_NONE;
            end
        end else if (dneg) begin
            n_d_side.fixed  = 1'b1;
            n_d_side.fix_st = qrr_pkg::ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_disc   <= n_disc;
        r_d_side <= n_d_side;
    end

    // square-root cell chain
    logic [qrr_pkg::SQR_W-1:0] w_sq_rem  [qrr_pkg::SQ_W+1];
    logic [qrr_pkg::SQ_W-1:0]  w_sq_root [qrr_pkg::SQ_W+1];
    logic [qrr_pkg::RAD_W-1:0] w_sq_rad  [qrr_pkg::SQ_W+1];

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = qrr_pkg::RAD_W'({r_disc, {(2*qrr_pkg::FRAC_BITS){1'b0}}});

    for (genvar k = 0; k < qrr_pkg::SQ_W; k++) begin : g_sq
        qrr_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .i_rad  (w_sq_rad[k]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1]),
            .o_rad  (w_sq_rad[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= r_d_side;
        for (int k = 1; k < qrr_pkg::SQ_W; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end
    end

    // stage n: numerators, rounding offset and divisors
    t_sq_side w_ns;
    logic [qrr_pkg::SQ_W-1:0]   w_s;
    logic signed [qrr_pkg::NV_W-1:0] w_nb, w_nc, w_sx, w_nump, w_numm;
    logic [qrr_pkg::NUM_W-1:0]  w_magp, w_magm;
    logic [qrr_pkg::DEN_W-1:0]  w_den;
    logic [qrr_pkg::QW-1:0]     n_tp, n_tm;
    logic [qrr_pkg::DEN_W:0]    n_d2;
    logic [qrr_pkg::QW-1:0]     r_tp, r_tm;
    logic [qrr_pkg::DEN_W:0]    r_d2;

    assign w_ns = r_sq_side[qrr_pkg::SQ_W-1];
    assign w_s  = w_sq_root[qrr_pkg::SQ_W];

    always_comb begin
        logic signed [qrr_pkg::NV_W-1:0] bsh, csh;
        logic signed [qrr_pkg::NV_W-1:0] absp, absm;
        bsh  = qrr_pkg::NV_W'({w_ns.bm, {qrr_pkg::FRAC_BITS{1'b0}}});
        csh  = qrr_pkg::NV_W'({w_ns.cm, {qrr_pkg::FRAC_BITS{1'b0}}});
        // -b and -c scaled by 2^frac
        w_nb = w_ns.bn ? bsh : -bsh;
        w_nc = w_ns.cn ? csh : -csh;
        w_sx = qrr_pkg::NV_W'(w_s);
        if (w_ns.lin) begin
            w_nump = w_nc;
            w_numm = '0;
            w_den  = qrr_pkg::DEN_W'(w_ns.bm);
        end else begin
            w_nump = w_nb + w_sx;
            w_numm = w_nb - w_sx;
            w_den  = {w_ns.am, 1'b0};
        end
        absp   = w_nump[qrr_pkg::NV_W-1] ? -w_nump : w_nump;
        absm   = w_numm[qrr_pkg::NV_W-1] ? -w_numm : w_numm;
        w_magp = absp[qrr_pkg::NUM_W-1:0];
        w_magm = absm[qrr_pkg::NUM_W-1:0];
        // 2|n| + den, divided later by 2*den
        n_tp   = {1'b0, w_magp, 1'b0} + qrr_pkg::QW'(w_den);
        n_tm   = {1'b0, w_magm, 1'b0} + qrr_pkg::QW'(w_den);
        n_d2   = {w_den, 1'b0};

        n_n_side.neg_p = w_nump[qrr_pkg::NV_W-1] ^ (w_ns.lin ? w_ns.bn : w_ns.an);
        n_n_side.neg_m = w_numm[qrr_pkg::NV_W-1] ^ w_ns.an;
        if (w_ns.fixed) begin
            n_n_side.st = w_ns.fix_st;
        end else if (w_s == '0) begin
            n_n_side.st = qrr_pkg::ST_ONE;
        end else begin
            n_n_side.st = qrr_pkg::ST_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tp <= n_tp;
        r_tm <= n_tm;
        r_d2 <= n_d2;
    end

    // two divider cell chains, plus and minus root
    logic [qrr_pkg::DEN_W:0] w_p_rem [qrr_pkg::QW+1];
    logic [qrr_pkg::QW-1:0]  w_p_t   [qrr_pkg::QW+1];
    logic [qrr_pkg::QW-1:0]  w_p_q   [qrr_pkg::QW+1];
    logic [qrr_pkg::DEN_W:0] w_p_d2  [qrr_pkg::QW+1];
    logic [qrr_pkg::DEN_W:0] w_m_rem [qrr_pkg::QW+1];
    logic [qrr_pkg::QW-1:0]  w_m_t   [qrr_pkg::QW+1];
    logic [qrr_pkg::QW-1:0]  w_m_q   [qrr_pkg::QW+1];
    logic [qrr_pkg::DEN_W:0] w_m_d2  [qrr_pkg::QW+1];

    assign w_p_rem[0] = '0;
    assign w_p_t[0]   = r_tp;
    assign w_p_q[0]   = '0;
    assign w_p_d2[0]  = r_d2;
    assign w_m_rem[0] = '0;
    assign w_m_t[0]   = r_tm;
    assign w_m_q[0]   = '0;
    assign w_m_d2[0]  = r_d2;

    for (genvar k = 0; k < qrr_pkg::QW; k++) begin : g_dv
        qrr_div_cell u_plus (
            .i_clk (i_clk),
            .i_rem (w_p_rem[k]),
            .i_t   (w_p_t[k]),
            .i_q   (w_p_q[k]),
            .i_d2  (w_p_d2[k]),
            .o_rem (w_p_rem[k+1]),
            .o_t   (w_p_t[k+1]),
            .o_q   (w_p_q[k+1]),
            .o_d2  (w_p_d2[k+1])
        );
        qrr_div_cell u_minus (
            .i_clk (i_clk),
            .i_rem (w_m_rem[k]),
            .i_t   (w_m_t[k]),
            .i_q   (w_m_q[k]),
            .i_d2  (w_m_d2[k]),
            .o_rem (w_m_rem[k+1]),
            .o_t   (w_m_t[k+1]),
            .o_q   (w_m_q[k+1]),
            .o_d2  (w_m_d2[k+1])
        );
    end

    t_dv_side r_n_side;

    always_ff @(posedge i_clk) begin
        r_n_side     <= n_n_side;
        r_dv_side[0] <= r_n_side;
        for (int k = 1; k < qrr_pkg::QW; k++) begin
            r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // output register: sign, saturate, zero the roots that are absent
    t_dv_side w_os;
    logic [1:0]                 r_status, n_status;
    logic [qrr_pkg::OUT_W-1:0]  r_plus, n_plus, r_minus, n_minus;

    assign w_os = r_dv_side[qrr_pkg::QW-1];

    always_comb begin
        n_status = w_os.st;
        n_plus   = '0;
        n_minus  = '0;
        if (w_os.st == qrr_pkg::ST_ONE || w_os.st == qrr_pkg::ST_TWO) begin
            n_plus = sat_sign(w_p_q[qrr_pkg::QW], w_os.neg_p);
        end
        if (w_os.st == qrr_pkg::ST_TWO) begin
            n_minus = sat_sign(w_m_q[qrr_pkg::QW], w_os.neg_m);
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_plus   <= n_plus;
        r_minus  <= n_minus;
    end

    assign o_valid       = r_vld[qrr_pkg::LAT];
    assign o_root_status = r_status;
    assign o_root_plus   = r_plus;
    assign o_root_minus  = r_minus;

`ifndef SYNTHESIS
    // every accepted equation comes out as an o_valid beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(qrr_pkg::LAT+1) o_valid)
        else $error("result beat missing after fixed latency");

    // second root only with two roots
    a_minus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_status != qrr_pkg::ST_TWO |-> o_root_minus == '0)
        else $error("root_minus nonzero without two roots");

    // no root value when nothing or everything solves
    a_plus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_status == qrr_pkg::ST_NONE || o_root_status == qrr_pkg::ST_ALL)
        |-> o_root_plus == '0)
        else $error("root_plus nonzero without a root");
`endif

endmodule

@@ design/qrr_sqrt_cell.sv @@
module qrr_sqrt_cell (
    input  logic                         i_clk,
    input  logic [qrr_pkg::SQR_W-1:0]    i_rem,
    input  logic [qrr_pkg::SQ_W-1:0]     i_root,
    input  logic [qrr_pkg::RAD_W-1:0]    i_rad,
    output logic [qrr_pkg::SQR_W-1:0]    o_rem,
    output logic [qrr_pkg::SQ_W-1:0]     o_root,
    output logic [qrr_pkg::RAD_W-1:0]    o_rad
);

    logic [qrr_pkg::SQR_W-1:0] w_cur;
    logic [qrr_pkg::SQR_W-1:0] w_trial;
    logic                      w_ge;
    logic [qrr_pkg::SQR_W-1:0] n_rem;
    logic [qrr_pkg::SQ_W-1:0]  n_root;
    logic [qrr_pkg::RAD_W-1:0] n_rad;
    logic [qrr_pkg::SQR_W-1:0] r_rem;
    logic [qrr_pkg::SQ_W-1:0]  r_root;
    logic [qrr_pkg::RAD_W-1:0] r_rad;

    // bring down the next two radicand bits, try root*4+1
    always_comb begin
        w_cur   = {i_rem[qrr_pkg::SQR_W-3:0], i_rad[qrr_pkg::RAD_W-1:qrr_pkg::RAD_W-2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_cur >= w_trial);
        n_rem   = w_ge ? (w_cur - w_trial) : w_cur;
        n_root  = {i_root[qrr_pkg::SQ_W-2:0], w_ge};
        n_rad   = {i_rad[qrr_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

@@ design/qrr_div_cell.sv @@
module qrr_div_cell (
    input  logic                      i_clk,
    input  logic [qrr_pkg::DEN_W:0]   i_rem,
    input  logic [qrr_pkg::QW-1:0]    i_t,
    input  logic [qrr_pkg::QW-1:0]    i_q,
    input  logic [qrr_pkg::DEN_W:0]   i_d2,
    output logic [qrr_pkg::DEN_W:0]   o_rem,
    output logic [qrr_pkg::QW-1:0]    o_t,
    output logic [qrr_pkg::QW-1:0]    o_q,
    output logic [qrr_pkg::DEN_W:0]   o_d2
);

    logic [qrr_pkg::DEN_W+1:0] w_r2;
    logic [qrr_pkg::DEN_W+1:0] w_diff;
    logic                      w_ge;
    logic [qrr_pkg::DEN_W:0]   n_rem;
    logic [qrr_pkg::QW-1:0]    n_t;
    logic [qrr_pkg::QW-1:0]    n_q;
    logic [qrr_pkg::DEN_W:0]   r_rem;
    logic [qrr_pkg::QW-1:0]    r_t;
    logic [qrr_pkg::QW-1:0]    r_q;
    logic [qrr_pkg::DEN_W:0]   r_d2;

    // restoring division, one quotient bit
    always_comb begin
        w_r2   = {i_rem, i_t[qrr_pkg::QW-1]};
        w_diff = w_r2 - {1'b0, i_d2};
        w_ge   = (w_r2 >= {1'b0, i_d2});
        n_rem  = w_ge ? w_diff[qrr_pkg::DEN_W:0] : w_r2[qrr_pkg::DEN_W:0];
        n_t    = {i_t[qrr_pkg::QW-2:0], 1'b0};
        n_q    = {i_q[qrr_pkg::QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_t   <= n_t;
        r_q   <= n_q;
        r_d2  <= i_d2;
    end

    assign o_rem = r_rem;
    assign o_t   = r_t;
    assign o_q   = r_q;
    assign o_d2  = r_d2;

endmodule

@@ test/tb_top.sv @@
module tb_top;

    localparam logic signed [127:0] MAX_POS = (128'sd1 <<< (qrr_pkg::OUT_W - 1)) - 1;
    localparam logic signed [127:0] MIN_NEG = -(128'sd1 <<< (qrr_pkg::OUT_W - 1));

    // one solved equation
    typedef struct {
        qrr_pkg::t_status                 status;
        logic signed [qrr_pkg::OUT_W-1:0] plus;
        logic signed [qrr_pkg::OUT_W-1:0] minus;
    } t_roots;

    // directed beat: coefficients, plus a hand-typed answer where it is obvious
    typedef struct {
        logic signed [qrr_pkg::COEF_WIDTH-1:0] a;
        logic signed [qrr_pkg::COEF_WIDTH-1:0] b;
        logic signed [qrr_pkg::COEF_WIDTH-1:0] c;
        bit                                    typed;
        t_roots                                ans;
    } t_eqn;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_start;
    logic                                   o_busy;
    logic signed [qrr_pkg::COEF_WIDTH-1:0]  i_coef_a;
    logic signed [qrr_pkg::COEF_WIDTH-1:0]  i_coef_b;
    logic signed [qrr_pkg::COEF_WIDTH-1:0]  i_coef_c;
    logic                                   o_valid;
    logic [1:0]                             o_root_status;
    logic signed [qrr_pkg::OUT_W-1:0]       o_root_plus;
    logic signed [qrr_pkg::OUT_W-1:0]       o_root_minus;

    quadratic_real_root_solver_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .o_valid       (o_valid),
        .o_root_status (o_root_status),
        .o_root_plus   (o_root_plus),
        .o_root_minus  (o_root_minus)
    );

    t_roots pending_roots[$];
    int     fail_cnt;
    int     beats_sent;
    int     roots_checked;
    int     status_seen[4];
    bit     calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor square root, bit by bit
    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] bt;
        rem = n;
        res = '0;
        bt  = 128'd1 << 126;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // n / d rounded to nearest, ties away from zero, saturated to the root width
    function automatic logic signed [qrr_pkg::OUT_W-1:0] round_div(
        input logic signed [127:0] n,
        input logic signed [127:0] d
    );
        logic [127:0]        nm;
        logic [127:0]        dm;
        logic [127:0]        q;
        logic signed [127:0] r;
        bit                  neg;
        nm  = (n < 0) ? -n : n;
        dm  = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        q   = (2 * nm + dm) / (2 * dm);
        r   = neg ? -$signed(q) : $signed(q);
        if (r > MAX_POS) r = MAX_POS;
        if (r < MIN_NEG) r = MIN_NEG;
        return r[qrr_pkg::OUT_W-1:0];
    endfunction

    // expected roots of a*x^2 + b*x + c = 0
    function automatic t_roots solve_quadratic(
        input logic signed [qrr_pkg::COEF_WIDTH-1:0] a,
        input logic signed [qrr_pkg::COEF_WIDTH-1:0] b,
        input logic signed [qrr_pkg::COEF_WIDTH-1:0] c
    );
        t_roots              rt;
        logic signed [127:0] sa;
        logic signed [127:0] sb;
        logic signed [127:0] sc;
        logic signed [127:0] disc;
        logic signed [127:0] sq;
        sa = a;
        sb = b;
        sc = c;
        rt.status = qrr_pkg::ST_NONE;
        rt.plus   = '0;
        rt.minus  = '0;
        if (sa == 0) begin
            // linear, degenerate or identity
            if (sb == 0) begin
                rt.status = (sc == 0) ? qrr_pkg::ST_ALL : qrr_pkg::ST_NONE;
            end else begin
                rt.status = qrr_pkg::ST_ONE;
                rt.plus   = round_div(-(sc <<< qrr_pkg::FRAC_BITS), sb);
            end
            return rt;
        end
        disc = sb * sb - 4 * sa * sc;
        if (disc < 0) return rt;
        sq = $signed(isqrt(disc << (2 * qrr_pkg::FRAC_BITS)));
        rt.plus = round_div(-(sb <<< qrr_pkg::FRAC_BITS) + sq, 2 * sa);
        if (sq == 0) begin
            rt.status = qrr_pkg::ST_ONE;
        end else begin
            rt.status = qrr_pkg::ST_TWO;
            rt.minus  = round_div(-(sb <<< qrr_pkg::FRAC_BITS) - sq, 2 * sa);
        end
        return rt;
    endfunction

    // drive one beat; start only changes on a falling edge
    task automatic send_eqn(input t_eqn e);
        while (!calm && $urandom_range(99) < 22) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start  <= 1'b1;
        i_coef_a <= e.a;
        i_coef_b <= e.b;
        i_coef_c <= e.c;
        do @(posedge i_clk); while (o_busy);
        pending_roots.push_back(e.typed ? e.ans : solve_quadratic(e.a, e.b, e.c));
        beats_sent++;
        @(negedge i_clk);
    endtask

    // random coefficient, mostly full range, sometimes small or at the extremes
    function automatic logic signed [qrr_pkg::COEF_WIDTH-1:0] pick_coef();
        int k;
        k = $urandom_range(9);
        if (k < 5) return qrr_pkg::COEF_WIDTH'($urandom());
        if (k < 8) return qrr_pkg::COEF_WIDTH'($signed($urandom_range(16)) - 8);
        if (k == 8) return {1'b1, {(qrr_pkg::COEF_WIDTH-1){1'b0}}};
        return {1'b0, {(qrr_pkg::COEF_WIDTH-1){1'b1}}};
    endfunction

    // result monitor: no backpressure, so every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_valid) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d plus %0d minus %0d",
                         $time, o_root_status, o_root_plus, o_root_minus);
                fail_cnt++;
            end else begin
                want = pending_roots.pop_front();
                roots_checked++;
                status_seen[o_root_status]++;
                if (o_root_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_root_status);
                    fail_cnt++;
                end
                if (o_root_plus !== want.plus) begin
                    $display("%0t: root_plus expected %0d got %0d",
                             $time, want.plus, o_root_plus);
                    fail_cnt++;
                end
                if (o_root_minus !== want.minus) begin
                    $display("%0t: root_minus expected %0d got %0d",
                             $time, want.minus, o_root_minus);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        t_eqn dir_tbl[$];
        t_eqn e;
        int   waited;
        fail_cnt      = 0;
        beats_sent    = 0;
        roots_checked = 0;
        calm          = 1'b0;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_coef_a = '0;
        i_coef_b = '0;
        i_coef_c = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity, no-root, linear, one and two roots, extremes
        dir_tbl.push_back('{0, 0, 0, 1, '{qrr_pkg::ST_ALL, 0, 0}});
        dir_tbl.push_back('{0, 0, 5, 1, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{0, 0, -32768, 1, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{0, 2, -4, 1,
                           '{qrr_pkg::ST_ONE, 40'sd2 <<< qrr_pkg::FRAC_BITS, 0}});
        dir_tbl.push_back('{0, -3, 1, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{0, 1, -32768, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{0, -32768, 32767, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{1, 0, 1, 1, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{1, -2, 1, 1,
                           '{qrr_pkg::ST_ONE, 40'sd1 <<< qrr_pkg::FRAC_BITS, 0}});
        dir_tbl.push_back('{1, 0, -1, 1,
                           '{qrr_pkg::ST_TWO, 40'sd1 <<< qrr_pkg::FRAC_BITS,
                             -(40'sd1 <<< qrr_pkg::FRAC_BITS)}});
        dir_tbl.push_back('{3, 7, 2, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{-5, 3, 11, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{2, 3, 0, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{1, -32768, 0, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{1, 32767, -32768, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{-32768, -32768, -32768, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{32767, 32767, 32767, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{-32768, 0, 32767, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{32767, -32768, -32768, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{-1, -1, -1, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{-32768, 0, 0, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        dir_tbl.push_back('{4, 4, 1, 0, '{qrr_pkg::ST_NONE, 0, 0}});
        foreach (dir_tbl[i]) send_eqn(dir_tbl[i]);

        // random: linear mix, perfect squares for double roots, and general coefficients
        for (int n = 0; n < 1830; n++) begin
            calm = (n >= 600 && n < 900);
            e.typed = 1'b0;
            e.ans   = '{qrr_pkg::ST_NONE, 0, 0};
            case ($urandom_range(9))
                0, 1: begin
                    e.a = 0;
                    e.b = pick_coef();
                    e.c = pick_coef();
                end
                2: begin
                    // a*(x-r)^2 gives a zero discriminant
                    e.a = qrr_pkg::COEF_WIDTH'($signed($urandom_range(60)) - 30);
                    e.b = qrr_pkg::COEF_WIDTH'(-2 * e.a * ($signed($urandom_range(20)) - 10));
                    e.c = qrr_pkg::COEF_WIDTH'(e.b * e.b / (4 * (e.a == 0 ? 1 : e.a)));
                    if (e.a == 0) e.a = 1;
                end
                default: begin
                    e.a = pick_coef();
                    e.b = pick_coef();
                    e.c = pick_coef();
                end
            endcase
            send_eqn(e);
        end
        i_start <= 1'b0;

        waited = 0;
        while (pending_roots.size() != 0 && waited < 10 * qrr_pkg::LAT + 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (qrr_pkg::LAT + 10) @(posedge i_clk);
        if (pending_roots.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_roots.size());
            fail_cnt++;
        end

        $display("sent %0d equations, checked %0d results, %0d mismatches",
                 beats_sent, roots_checked, fail_cnt);
        $display("status mix: none %0d one %0d two %0d all %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
